/* src/plcs_pkg.sv */
// Shared widths, constants, state types and helpers of the per-class latency statistics unit.
`timescale 1ns / 1ps

package plcs_pkg;

	// Table geometry.
	localparam int NUM_CLASSES = 8;
	localparam int ROW_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

	// Field widths.
	localparam int CLASS_W = 8;
	localparam int SEC_W   = 32;
	localparam int NSEC_W  = 30;
	localparam int OPS_W   = 16;
	localparam int CNT_W   = 32;
	localparam int MEAN_W  = 48;

	// Stream widths.
	localparam int S_DATA_W = 224;
	localparam int M_DATA_W = 192;

	// Span arithmetic: seconds difference, nanoseconds difference, signed ns.
	localparam int DS_W     = SEC_W + 1;
	localparam int DN_W     = NSEC_W + 1;
	localparam int NS_W     = 44;
	localparam int NS_MAG_W = 42;
	localparam int DS_MAG_W = 13;
	localparam int Q_SHIFT  = 13;                     // 2^16 / 1000 = 2^13 / 125
	localparam logic [CNT_W-1:0] US_DIVISOR = CNT_W'(125);

	localparam logic [NS_W-1:0] NSEC_PER_SEC = NS_W'(64'd1000000000);
	localparam logic [NS_W-1:0] SAT_NS       = NS_W'(64'd4294967296000);
	localparam logic signed [DS_W-1:0] DS_SAT_MIN  = DS_W'(64'sd4297);
	localparam logic signed [DS_W-1:0] DS_ZERO_MAX = -DS_W'(64'sd2);

	localparam logic [MEAN_W-1:0] MEAN_MAX = '1;
	localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

	// Serial divider.
	localparam int DVD_W  = NS_MAG_W + Q_SHIFT;
	localparam int ITER_W = $clog2(DVD_W + 1);
	localparam logic [ITER_W-1:0] ITERS_SPAN = ITER_W'(DVD_W);
	localparam logic [ITER_W-1:0] ITERS_MEAN = ITER_W'(MEAN_W);

	typedef enum logic [1:0] {
		T_IDLE,
		T_RUN,
		T_FIN
	} top_state_t;

	typedef enum logic [2:0] {
		L_IDLE,
		L_NS,
		L_SAMP,
		L_DIVA,
		L_MEAN,
		L_DIVB,
		L_DONE
	} lane_state_t;

	typedef struct packed {
		logic              done;
		logic [MEAN_W-1:0] mean;
	} lane_stat_t;

	function automatic logic [CNT_W-1:0] sat_add32(input logic [CNT_W-1:0] a,
		input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
	endfunction

endpackage

/* src/plcs_div.sv */
// Restoring divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps

module plcs_div
	import plcs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DVD_W-1:0]  dividend,
	input  logic [CNT_W-1:0]  divisor,
	input  logic [ITER_W-1:0] iters,
	output logic              done,
	output logic [MEAN_W-1:0] quotient
);

	logic [DVD_W-1:0]  dvd_q;
	logic [DVD_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dsr_q;
	logic [ITER_W-1:0] cnt_q;
	logic              done_q;
	logic [CNT_W:0]    trial;
	logic              fits;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= iters;
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - ITER_W'(1);
			done_q <= (cnt_q == ITER_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			// shift in the next dividend bit, subtract when the divisor fits
			rem_q <= fits ? CNT_W'(trial - {1'b0, dsr_q}) : trial[CNT_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[MEAN_W-1:0];

endmodule

/* src/plcs_lane.sv */
// One time span: sample in Q32.16 microseconds, then the running mean step.
`timescale 1ns / 1ps

module plcs_lane
	import plcs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SEC_W-1:0]  a_sec,
	input  logic [NSEC_W-1:0] a_nsec,
	input  logic [SEC_W-1:0]  b_sec,
	input  logic [NSEC_W-1:0] b_nsec,
	input  logic [MEAN_W-1:0] mean_in,
	input  logic [CNT_W-1:0]  count_in,
	output lane_stat_t        stat
);

	lane_state_t state_q, state_d;

	logic signed [DS_W-1:0] ds_q;
	logic signed [DN_W-1:0] dn_q;
	logic [NS_W-1:0]        ns_q;
	logic                   big_q;
	logic                   neg_q;
	logic [MEAN_W-1:0]      mean_q;
	logic [MEAN_W-1:0]      sample_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   ge_q;

	logic [NS_W-1:0]   dn_ext;
	logic [NS_W-1:0]   ns_next;
	logic              is_zero;
	logic              is_sat;
	logic              ge;
	logic [MEAN_W-1:0] diff;

	logic              div_start;
	logic [DVD_W-1:0]  div_dividend;
	logic [CNT_W-1:0]  div_divisor;
	logic [ITER_W-1:0] div_iters;
	logic              div_done;
	logic [MEAN_W-1:0] div_quo;

	assign dn_ext  = {{(NS_W-DN_W){dn_q[DN_W-1]}}, dn_q};
	// seconds difference of minus one takes the short path; others are non-negative here
	assign ns_next = ds_q[DS_W-1] ? (dn_ext - NSEC_PER_SEC)
		: (NS_W'(ds_q[DS_MAG_W-1:0]) * NSEC_PER_SEC + dn_ext);

	assign is_zero = neg_q || (!big_q && (ns_q[NS_W-1] || ns_q == '0));
	assign is_sat  = big_q || (!ns_q[NS_W-1] && ns_q >= SAT_NS);
	assign ge      = sample_q >= mean_q;
	assign diff    = ge ? (sample_q - mean_q) : (mean_q - sample_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_dividend = {ns_q[NS_MAG_W-1:0], {Q_SHIFT{1'b0}}};
		div_divisor  = US_DIVISOR;
		div_iters    = ITERS_SPAN;
		case (state_q)
			L_IDLE: begin
				if (start) state_d = L_NS;
			end
			L_NS: state_d = L_SAMP;
			L_SAMP: begin
				if (is_zero || is_sat) begin
					state_d = L_MEAN;
				end else begin
					div_start = 1'b1;
					state_d   = L_DIVA;
				end
			end
			L_DIVA: begin
				if (div_done) state_d = L_MEAN;
			end
			L_MEAN: begin
				div_start    = 1'b1;
				div_dividend = {diff, {(DVD_W-MEAN_W){1'b0}}};
				div_divisor  = cnt_q;
				div_iters    = ITERS_MEAN;
				state_d      = L_DIVB;
			end
			L_DIVB: begin
				if (div_done) state_d = L_DONE;
			end
			L_DONE: state_d = L_IDLE;
			default: state_d = L_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			L_IDLE: begin
				if (start) begin
					ds_q   <= $signed({1'b0, b_sec}) - $signed({1'b0, a_sec});
					dn_q   <= $signed({1'b0, b_nsec}) - $signed({1'b0, a_nsec});
					mean_q <= mean_in;
					cnt_q  <= count_in;
				end
			end
			L_NS: begin
				ns_q  <= ns_next;
				big_q <= ds_q >= DS_SAT_MIN;
				neg_q <= ds_q <= DS_ZERO_MAX;
			end
			L_SAMP: begin
				if (is_zero) sample_q <= '0;
				else if (is_sat) sample_q <= MEAN_MAX;
			end
			L_DIVA: begin
				if (div_done) sample_q <= div_quo;
			end
			L_MEAN: ge_q <= ge;
			L_DIVB: begin
				// the step never exceeds the distance, so no wrap either way
				if (div_done) mean_q <= ge_q ? (mean_q + div_quo) : (mean_q - div_quo);
			end
			default: ;
		endcase
	end

	plcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.iters    (div_iters),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign stat = '{done: (state_q == L_DONE), mean: mean_q};

endmodule

/* src/per_class_latency_stats_unit.sv */
// Top level: class table, request control and result register.
//
//  channel | signals                          | accepted when
//  --------+----------------------------------+------------------------------
//  in      | s_tvalid s_tready s_tdata s_tuser| s_tvalid & s_tready
//  out     | m_tvalid m_tready m_tdata m_tuser| m_tvalid & m_tready
//  config  | cfg_we cfg_wdata                 | cfg_we
//
// A request that updates the table starts both span lanes on acceptance: each span lane
// runs two serial divisions in series (55 bits for the microsecond scaling, 48 bits for the
// mean step), one quotient bit per cycle, and the two lanes run side by side;
// a sample that clamps to zero or saturates skips the first division.
// A request with a bad class or with updates disabled skips the lanes; reset clears the table.
// A finished result waits in the output register while the next request is taken.
`timescale 1ns / 1ps

module per_class_latency_stats_unit
	import plcs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                s_tvalid,
	output logic                s_tready,
	// enqueue_sec, enqueue_nsec, start_sec, start_nsec, end_sec, end_nsec,
	// task_aborts, task_commits, zero fill
	input  logic [S_DATA_W-1:0] s_tdata,
	// task_class
	input  logic [CLASS_W-1:0]  s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// class_count, class_mean_wait, class_mean_exec, class_total_aborts,
	// class_total_commits
	output logic [M_DATA_W-1:0] m_tdata,
	// accepted
	output logic [0:0]          m_tuser
);

	top_state_t state_q, state_d;

	logic update_enable_q;

	logic [CNT_W-1:0]  cnt_tab_q    [NUM_CLASSES];
	logic [MEAN_W-1:0] wait_tab_q   [NUM_CLASSES];
	logic [MEAN_W-1:0] exec_tab_q   [NUM_CLASSES];
	logic [CNT_W-1:0]  abort_tab_q  [NUM_CLASSES];
	logic [CNT_W-1:0]  commit_tab_q [NUM_CLASSES];

	logic [ROW_W-1:0]  row_q;
	logic              en_q;
	logic [CNT_W-1:0]  res_cnt_q;
	logic [MEAN_W-1:0] res_wait_q;
	logic [MEAN_W-1:0] res_exec_q;
	logic [CNT_W-1:0]  res_abort_q;
	logic [CNT_W-1:0]  res_commit_q;
	logic              wdone_q;
	logic              edone_q;

	logic                m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;
	logic                m_tuser_q;

	logic              accept;
	logic              load;
	logic              lane_start;
	logic              cls_ok;
	logic              upd;
	logic [ROW_W-1:0]  row;
	logic [CNT_W-1:0]  rd_cnt;
	logic [MEAN_W-1:0] rd_wait;
	logic [MEAN_W-1:0] rd_exec;
	logic [CNT_W-1:0]  rd_abort;
	logic [CNT_W-1:0]  rd_commit;
	logic [CNT_W-1:0]  cnt_inc;
	lane_stat_t        wstat;
	lane_stat_t        estat;

	logic [SEC_W-1:0]  enq_sec, sta_sec, end_sec;
	logic [NSEC_W-1:0] enq_nsec, sta_nsec, end_nsec;
	logic [OPS_W-1:0]  aborts, commits;

	assign enq_sec  = s_tdata[31:0];
	assign enq_nsec = s_tdata[61:32];
	assign sta_sec  = s_tdata[93:62];
	assign sta_nsec = s_tdata[123:94];
	assign end_sec  = s_tdata[155:124];
	assign end_nsec = s_tdata[185:156];
	assign aborts   = s_tdata[201:186];
	assign commits  = s_tdata[217:202];

	assign cls_ok = (s_tuser != '0) && (s_tuser <= CLASS_W'(NUM_CLASSES));
	assign row    = ROW_W'(s_tuser - CLASS_W'(1));
	assign upd    = cls_ok && update_enable_q;

	// drop reads for a bad class: they report zero
	assign rd_cnt    = cls_ok ? cnt_tab_q[row]    : '0;
	assign rd_wait   = cls_ok ? wait_tab_q[row]   : '0;
	assign rd_exec   = cls_ok ? exec_tab_q[row]   : '0;
	assign rd_abort  = cls_ok ? abort_tab_q[row]  : '0;
	assign rd_commit = cls_ok ? commit_tab_q[row] : '0;
	assign cnt_inc   = sat_add32(rd_cnt, CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			update_enable_q <= 1'b0;
		end else if (cfg_we) begin
			update_enable_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		load       = 1'b0;
		case (state_q)
			T_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = upd ? T_RUN : T_FIN;
			end
			T_RUN: begin
				if ((wdone_q || wstat.done) && (edone_q || estat.done)) state_d = T_FIN;
			end
			T_FIN: begin
				if (!m_tvalid_q || m_tready) begin
					load    = 1'b1;
					state_d = T_IDLE;
				end
			end
			default: state_d = T_IDLE;
		endcase
	end

	assign accept     = s_tvalid && s_tready;
	assign lane_start = accept && upd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wdone_q <= 1'b0;
			edone_q <= 1'b0;
			en_q    <= 1'b0;
		end else if (accept) begin
			wdone_q <= 1'b0;
			edone_q <= 1'b0;
			en_q    <= upd;
		end else begin
			if (wstat.done) wdone_q <= 1'b1;
			if (estat.done) edone_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_q        <= row;
			res_cnt_q    <= upd ? cnt_inc : rd_cnt;
			res_wait_q   <= rd_wait;
			res_exec_q   <= rd_exec;
			res_abort_q  <= upd ? sat_add32(rd_abort, CNT_W'(aborts)) : rd_abort;
			res_commit_q <= upd ? sat_add32(rd_commit, CNT_W'(commits)) : rd_commit;
		end else begin
			if (wstat.done) res_wait_q <= wstat.mean;
			if (estat.done) res_exec_q <= estat.mean;
		end
	end

	// write back the row as the result is loaded into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				cnt_tab_q[i]    <= '0;
				wait_tab_q[i]   <= '0;
				exec_tab_q[i]   <= '0;
				abort_tab_q[i]  <= '0;
				commit_tab_q[i] <= '0;
			end
		end else if (load && en_q) begin
			cnt_tab_q[row_q]    <= res_cnt_q;
			wait_tab_q[row_q]   <= res_wait_q;
			exec_tab_q[row_q]   <= res_exec_q;
			abort_tab_q[row_q]  <= res_abort_q;
			commit_tab_q[row_q] <= res_commit_q;
		end
	end

	plcs_lane u_wait (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (lane_start),
		.a_sec    (enq_sec),
		.a_nsec   (enq_nsec),
		.b_sec    (sta_sec),
		.b_nsec   (sta_nsec),
		.mean_in  (rd_wait),
		.count_in (cnt_inc),
		.stat     (wstat)
	);

	plcs_lane u_exec (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (lane_start),
		.a_sec    (sta_sec),
		.a_nsec   (sta_nsec),
		.b_sec    (end_sec),
		.b_nsec   (end_nsec),
		.mean_in  (rd_exec),
		.count_in (cnt_inc),
		.stat     (estat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= {res_commit_q, res_abort_q, res_exec_q, res_wait_q, res_cnt_q};
			m_tuser_q <= en_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

/* src/plcs_chk.sv */
// Port-level checks of the per-class latency statistics unit, bound to the top level.
`timescale 1ns / 1ps

module plcs_chk
	import plcs_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic [0:0]          m_tuser
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one request at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	// an update always leaves a nonzero count
	a_acc_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[31:0] != '0)
		else $error("accepted result with zero count");

	// a row never updated reports all zero
	a_empty_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[31:0] == '0 |-> m_tdata[M_DATA_W-1:32] == '0 && !m_tuser[0])
		else $error("empty row with nonzero statistics");

endmodule

bind per_class_latency_stats_unit plcs_chk u_plcs_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* test/testbench.sv */
// Self-checking testbench for the per-class latency statistics unit.
`timescale 1ns / 1ps

module testbench;
	import plcs_pkg::*;

	localparam int DRAIN_CYCLES = 150;

	typedef struct packed {
		logic [CLASS_W-1:0] cls;
		logic [SEC_W-1:0]   enq_s;
		logic [NSEC_W-1:0]  enq_ns;
		logic [SEC_W-1:0]   start_s;
		logic [NSEC_W-1:0]  start_ns;
		logic [SEC_W-1:0]   end_s;
		logic [NSEC_W-1:0]  end_ns;
		logic [OPS_W-1:0]   aborts;
		logic [OPS_W-1:0]   commits;
	} task_rec_t;

	typedef struct packed {
		logic              accepted;
		logic [CNT_W-1:0]  count;
		logic [MEAN_W-1:0] avg_wait;
		logic [MEAN_W-1:0] avg_run;
		logic [CNT_W-1:0]  aborts;
		logic [CNT_W-1:0]  commits;
	} class_stats_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic                cfg_wdata = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [CLASS_W-1:0]  s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [0:0]          m_tuser;

	// Expected class statistics, oldest first.
	class_stats_t stats_expected [$];

	logic              model_update_en = 1'b0;
	logic [CNT_W-1:0]  tbl_count   [NUM_CLASSES] = '{default: '0};
	logic [MEAN_W-1:0] tbl_wait    [NUM_CLASSES] = '{default: '0};
	logic [MEAN_W-1:0] tbl_exec    [NUM_CLASSES] = '{default: '0};
	logic [CNT_W-1:0]  tbl_aborts  [NUM_CLASSES] = '{default: '0};
	logic [CNT_W-1:0]  tbl_commits [NUM_CLASSES] = '{default: '0};

	bit          tx_idle_en = 1'b0;
	bit          rx_idle_en = 1'b0;
	int unsigned rx_hold_left = 0;
	int unsigned mismatches = 0;
	int unsigned n_sent = 0;
	int unsigned n_checked = 0;
	int unsigned n_updates = 0;

	per_class_latency_stats_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Time from a to b in Q32.16 microseconds; clamp negatives, saturate long spans.
	function automatic logic [MEAN_W-1:0] span_q16_us(logic [SEC_W-1:0] a_s,
		logic [NSEC_W-1:0] a_ns, logic [SEC_W-1:0] b_s, logic [NSEC_W-1:0] b_ns);
		longint          ds;
		longint          dn;
		longint          ns;
		longint unsigned mag;
		longint unsigned whole;
		longint unsigned rem;
		ds = longint'(b_s) - longint'(a_s);
		dn = longint'(b_ns) - longint'(a_ns);
		ns = ds * 64'sd1000000000 + dn;
		if (ns <= 0)
			return '0;
		mag = ns;
		whole = mag / 1000;
		rem = mag % 1000;
		if (whole > 64'hFFFF_FFFF)
			return '1;
		return {32'(whole), 16'((rem << 16) / 1000)};
	endfunction

	function automatic logic [MEAN_W-1:0] mean_toward(logic [MEAN_W-1:0] m,
		logic [MEAN_W-1:0] smp, logic [CNT_W-1:0] n);
		logic [MEAN_W-1:0] n_w;
		n_w = MEAN_W'(n);
		if (n == 0)
			return m;
		if (smp >= m)
			return m + (smp - m) / n_w;
		return m - (m - smp) / n_w;
	endfunction

	function automatic logic [CNT_W-1:0] add_clip32(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? '1 : s[CNT_W-1:0];
	endfunction

	function automatic class_stats_t update_class_table(task_rec_t r);
		class_stats_t o;
		int           row;
		o = '0;
		if (r.cls == 0 || r.cls > NUM_CLASSES)
			return o;
		row = r.cls - 1;
		if (model_update_en) begin
			tbl_aborts[row] = add_clip32(tbl_aborts[row], CNT_W'(r.aborts));
			tbl_commits[row] = add_clip32(tbl_commits[row], CNT_W'(r.commits));
			tbl_count[row] = add_clip32(tbl_count[row], 1);
			tbl_wait[row] = mean_toward(tbl_wait[row],
				span_q16_us(r.enq_s, r.enq_ns, r.start_s, r.start_ns), tbl_count[row]);
			tbl_exec[row] = mean_toward(tbl_exec[row],
				span_q16_us(r.start_s, r.start_ns, r.end_s, r.end_ns), tbl_count[row]);
			o.accepted = 1'b1;
		end
		o.count = tbl_count[row];
		o.avg_wait = tbl_wait[row];
		o.avg_run = tbl_exec[row];
		o.aborts = tbl_aborts[row];
		o.commits = tbl_commits[row];
		return o;
	endfunction

	// Mostly short gaps, a few long ones.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic task_rec_t make_rec(int cls, logic [31:0] es, logic [29:0] ens,
		logic [31:0] ss, logic [29:0] sns, logic [31:0] xs, logic [29:0] xns,
		logic [15:0] ab, logic [15:0] cm);
		task_rec_t r;
		r = '{cls: CLASS_W'(cls), enq_s: es, enq_ns: ens, start_s: ss, start_ns: sns,
			end_s: xs, end_ns: xns, aborts: ab, commits: cm};
		return r;
	endfunction

	function automatic longint unsigned random_delta();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 2000);
			1: return $urandom_range(0, 100_000_000);
			// around the 2^32 microsecond saturation point
			2: return longint'($urandom) * 1200;
			default: return {$urandom, $urandom} % 64'd20_000_000_000_000;
		endcase
	endfunction

	function automatic void advance_ts(inout logic [SEC_W-1:0] s, inout logic [NSEC_W-1:0] ns,
		input longint unsigned d);
		longint unsigned total;
		total = longint'(ns) + d;
		s = s + SEC_W'(total / 1000000000);
		ns = NSEC_W'(total % 1000000000);
	endfunction

	function automatic task_rec_t random_record();
		task_rec_t   r;
		int unsigned sel;
		sel = $urandom_range(0, 19);
		if (sel < 17)
			r.cls = CLASS_W'($urandom_range(1, NUM_CLASSES));
		else if (sel == 17)
			r.cls = '0;
		else if (sel == 18)
			r.cls = CLASS_W'($urandom_range(NUM_CLASSES + 1, 255));
		else
			r.cls = CLASS_W'($urandom);
		r.aborts = OPS_W'($urandom);
		r.commits = OPS_W'($urandom);
		if ($urandom_range(0, 9) < 8) begin
			// well-formed: enqueue <= start <= end, modulo second wrap
			r.enq_s = $urandom;
			r.enq_ns = NSEC_W'($urandom_range(0, 999_999_999));
			r.start_s = r.enq_s;
			r.start_ns = r.enq_ns;
			advance_ts(r.start_s, r.start_ns, random_delta());
			r.end_s = r.start_s;
			r.end_ns = r.start_ns;
			advance_ts(r.end_s, r.end_ns, random_delta());
		end else begin
			r.enq_s = $urandom;
			r.enq_ns = NSEC_W'($urandom);
			r.start_s = $urandom;
			r.start_ns = NSEC_W'($urandom);
			r.end_s = $urandom;
			r.end_ns = NSEC_W'($urandom);
		end
		return r;
	endfunction

	task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch: expected %0h, got %0h", $realtime, field, want, got);
		end
	endtask

	// Present one request after a gap and hold it until taken.
	task automatic send_record(task_rec_t r);
		int unsigned gap;
		gap = tx_idle_en ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r.cls;
		s_tdata <= {6'b0, r.commits, r.aborts, r.end_ns, r.end_s, r.start_ns, r.start_s,
			r.enq_ns, r.enq_s};
		do
			@(posedge clk);
		while (!s_tready);
		stats_expected.push_back(update_class_table(r));
		n_sent++;
	endtask

	task automatic wait_drained();
		while (stats_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_update_enable(logic v);
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		model_update_en = v;
	endtask

	always @(negedge clk) begin
		if (rx_hold_left != 0) begin
			m_tready <= 1'b0;
			rx_hold_left <= rx_hold_left - 1;
		end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
			m_tready <= 1'b0;
			rx_hold_left <= pick_gap();
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		class_stats_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (stats_expected.size() == 0) begin
				check_field("unexpected result", 64'h0, 64'h1);
			end else begin
				want = stats_expected.pop_front();
				n_checked++;
				if (want.accepted)
					n_updates++;
				check_field("accepted", 64'(want.accepted), 64'(m_tuser[0]));
				check_field("class_count", 64'(want.count), 64'(m_tdata[31:0]));
				check_field("wait average", 64'(want.avg_wait), 64'(m_tdata[79:32]));
				check_field("execution average", 64'(want.avg_run), 64'(m_tdata[127:80]));
				check_field("class_total_aborts", 64'(want.aborts), 64'(m_tdata[159:128]));
				check_field("class_total_commits", 64'(want.commits), 64'(m_tdata[191:160]));
			end
		end
	end

	// With updates off after reset, each class sent reads as an empty row.
	task automatic test_disabled_after_reset();
		send_record(make_rec(1, 32'd3, 30'd0, 32'd4, 30'd5, 32'd9, 30'd7, 16'd2, 16'd1));
		send_record(make_rec(NUM_CLASSES, '1, '1, '1, '1, '1, '1, '1, '1));
		send_record(make_rec(0, 32'd1, 30'd1, 32'd2, 30'd2, 32'd3, 30'd3, 16'd1, 16'd1));
		send_record(make_rec(NUM_CLASSES + 1, 0, 0, 1, 0, 2, 0, 16'd9, 16'd9));
		send_record(make_rec(255, 0, 0, 1, 0, 2, 0, 16'd9, 16'd9));
	endtask

	task automatic test_span_corners();
		// plain short wait and execution
		send_record(make_rec(1, 32'd10, 30'd0, 32'd10, 30'd1500, 32'd10, 30'd4000,
			16'd3, 16'd5));
		// zero spans, full operation counts
		send_record(make_rec(NUM_CLASSES, 0, 0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF));
		// start before enqueue clamps to zero
		send_record(make_rec(2, 32'd100, 30'd500, 32'd99, 30'd999_999_999,
			32'd99, 30'd999_999_999, 16'd0, 16'd1));
		// longest possible wait saturates
		send_record(make_rec(3, 0, 0, '1, 30'd999_999_999, '1, 30'd999_999_999, 16'd1, 16'd0));
		// just under and just over 2^32 microseconds
		send_record(make_rec(4, 0, 0, 32'd4294, 30'd967_295_999, 32'd8589, 30'd934_592_000,
			16'd7, 16'd7));
		// nanosecond fields above one second
		send_record(make_rec(5, 32'd5, '1, 32'd6, 30'd0, 32'd6, '1, 16'd1, 16'd1));
		// bad classes while updates are on
		send_record(make_rec(0, 0, 0, 32'd1, 0, 32'd2, 0, 16'd4, 16'd4));
		send_record(make_rec(NUM_CLASSES + 1, 0, 0, 32'd1, 0, 32'd2, 0, 16'd4, 16'd4));
		send_record(make_rec(255, '1, '1, '1, '1, '1, '1, '1, '1));
		send_record(make_rec(6, '1, '1, '1, '1, '1, '1, '1, '1));
	endtask

	// Mean moves up, then down, truncating toward zero each time.
	task automatic test_mean_steps();
		send_record(make_rec(1, 32'd20, 30'd0, 32'd21, 30'd123, 32'd21, 30'd123, 16'd0, 16'd0));
		send_record(make_rec(1, 32'd30, 30'd0, 32'd30, 30'd1, 32'd35, 30'd777, 16'd0, 16'd0));
		send_record(make_rec(1, 32'd40, 30'd0, 32'd40, 30'd0, 32'd40, 30'd3, 16'd1, 16'd1));
	endtask

	task automatic test_disabled_hold();
		send_record(make_rec(1, 32'd1, 0, 32'd2, 0, 32'd3, 0, 16'd9, 16'd9));
		send_record(make_rec(4, 0, 0, 32'd5, 0, 32'd9, 0, 16'd9, 16'd9));
		send_record(make_rec(NUM_CLASSES, 0, 0, 32'd5, 0, 32'd9, 0, 16'd9, 16'd9));
	endtask

	task automatic test_random_traffic(int n, bit idle);
		tx_idle_en = idle;
		rx_idle_en = idle;
		for (int i = 0; i < n; i++) begin
			// hold off once until every pending result is back
			if (i == n / 2) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				wait_drained();
			end
			send_record(random_record());
		end
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		test_disabled_after_reset();
		set_update_enable(1'b1);
		test_span_corners();
		test_mean_steps();
		set_update_enable(1'b0);
		test_disabled_hold();

		set_update_enable(1'b1);
		test_random_traffic(450, 1'b1);
		set_update_enable(1'b0);
		test_random_traffic(100, 1'b1);
		set_update_enable(1'b1);
		test_random_traffic(150, 1'b0);
		test_random_traffic(400, 1'b1);

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		mismatches += stats_expected.size();

		$display("Sent %0d task records, checked %0d results, %0d of them table updates.",
			n_sent, n_checked, n_updates);
		$display("Covered updates on and off, bad classes, clamped and saturated spans.");
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* files.f */
src/plcs_pkg.sv
src/plcs_div.sv
src/plcs_lane.sv
src/per_class_latency_stats_unit.sv
src/plcs_chk.sv
test/testbench.sv
